@@ src/jsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

    localparam int RUN_MAX = 12;   // most output bytes one input byte can cause
    localparam int CNT_W   = 4;    // holds 0..RUN_MAX

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;   // 0xD800 under mask 0xFC00

    localparam logic [127:0] HEX_TEXT = "0123456789ABCDEF";

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX1    = 3'd2,
        PH_WANT_BS = 3'd3,
        PH_WANT_U  = 3'd4,
        PH_HEX2    = 3'd5
    } phase_t;

    // Output bytes caused by one input byte, first byte in data[0].
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] data;
        logic [CNT_W-1:0]        count;
        logic                    eos;
    } run_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return HEX_TEXT[{~n, 3'b000} +: 8];
    endfunction

endpackage

@@ src/jsu_parser.sv @@
`timescale 1ns / 1ps
// Escape-sequence state machine: decodes one input word per advance cycle into
// a run of output bytes and updates the escape state. Depends on jsu_pkg.
module jsu_parser
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output run_t       run,
    output phase_t     phase
);

    phase_t      phase_reg, phase_raw;
    logic [1:0]  seen_reg, seen_raw;
    logic [15:0] acc_reg, acc_raw;
    logic [9:0]  hs_reg, hs_next;

    logic [3:0]  nib;
    logic [15:0] acc_shift;
    logic        group_done;
    logic        is_high_surr;
    logic [20:0] cp;
    logic [3:0][7:0] u8;
    logic [2:0]  u8_len;
    run_t        utf8_run;
    run_t        base_run;

    function automatic run_t hex_run(input logic [7:0] v, input logic eos);
        run_t r;
        r       = '0;
        r.data[0] = CH_TILDE;
        r.data[1] = hex_char(v[7:4]);
        r.data[2] = hex_char(v[3:0]);
        r.count = CNT_W'(3);
        r.eos   = eos;
        return r;
    endfunction

    function automatic run_t byte_run(input logic [7:0] v, input logic eos);
        run_t r;
        r         = '0;
        r.data[0] = v;
        r.count   = CNT_W'(1);
        r.eos     = eos;
        return r;
    endfunction

    // Hex digits are not checked: letters fold onto ten and up
    assign nib          = (in_byte >= CH_UPPER_A) ? (in_byte[3:0] - 4'd7) : in_byte[3:0];
    assign acc_shift    = {acc_reg[11:0], nib};
    assign group_done   = (seen_reg == 2'd3);
    assign is_high_surr = (acc_shift[15:10] == SURR_HIGH_TAG);
    assign cp = (phase_reg == PH_HEX2)
              ? (21'h10000 + {1'b0, hs_reg, 10'd0} + {11'd0, acc_shift[9:0]})
              : {5'd0, acc_shift};

    // UTF-8 bytes of the finished code point
    always_comb
    begin
        u8 = '0;
        if (cp < 21'h80)
        begin
            u8[0]  = cp[7:0];
            u8_len = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            u8[0]  = {3'b110, cp[10:6]};
            u8[1]  = {2'b10, cp[5:0]};
            u8_len = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            u8[0]  = {4'b1110, cp[15:12]};
            u8[1]  = {2'b10, cp[11:6]};
            u8[2]  = {2'b10, cp[5:0]};
            u8_len = 3'd3;
        end
        else
        begin
            u8[0]  = {5'b11110, cp[20:18]};
            u8[1]  = {2'b10, cp[17:12]};
            u8[2]  = {2'b10, cp[11:6]};
            u8[3]  = {2'b10, cp[5:0]};
            u8_len = 3'd4;
        end
    end

    always_comb
    begin
        utf8_run = '0;
        for (int i = 0; i < 4; i++)
        begin
            utf8_run.data[3*i]   = CH_TILDE;
            utf8_run.data[3*i+1] = hex_char(u8[i][7:4]);
            utf8_run.data[3*i+2] = hex_char(u8[i][3:0]);
        end
        utf8_run.count = {1'b0, u8_len} + {u8_len, 1'b0};
        utf8_run.eos   = end_of_string;
    end

    // Next state, before the end-of-string override
    always_comb
    begin
        phase_raw = phase_reg;
        seen_raw  = seen_reg;
        acc_raw   = acc_reg;
        hs_next   = hs_reg;
        case (phase_reg)
            PH_ESC:
            begin
                if (in_byte == CH_LOW_U)
                begin
                    phase_raw = PH_HEX1;
                    seen_raw  = 2'd0;
                    acc_raw   = 16'd0;
                end
                else
                begin
                    phase_raw = PH_IDLE;
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                acc_raw = acc_shift;
                if (!group_done)
                begin
                    seen_raw = seen_reg + 2'd1;
                end
                else
                begin
                    seen_raw = 2'd0;
                    if (phase_reg == PH_HEX1 && is_high_surr)
                    begin
                        hs_next   = acc_shift[9:0];
                        phase_raw = PH_WANT_BS;
                    end
                    else
                    begin
                        phase_raw = PH_IDLE;
                    end
                end
            end
            PH_WANT_BS:
            begin
                phase_raw = (in_byte == CH_BSLASH) ? PH_WANT_U : PH_IDLE;
            end
            PH_WANT_U:
            begin
                if (in_byte == CH_LOW_U)
                begin
                    phase_raw = PH_HEX2;
                    seen_raw  = 2'd0;
                    acc_raw   = 16'd0;
                end
                else
                begin
                    // drop the backslash and take this byte from idle
                    phase_raw = (in_byte == CH_BSLASH) ? PH_ESC : PH_IDLE;
                end
            end
            default:
            begin
                phase_raw = (in_byte == CH_BSLASH) ? PH_ESC : PH_IDLE;
            end
        endcase
    end

    // Output run
    always_comb
    begin
        base_run     = '0;
        base_run.eos = end_of_string;
        case (phase_reg)
            PH_ESC:
            begin
                case (in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: base_run = byte_run(in_byte, end_of_string);
                    CH_LOW_B: base_run = hex_run(CTL_BS, end_of_string);
                    CH_LOW_F: base_run = hex_run(CTL_FF, end_of_string);
                    CH_LOW_N: base_run = hex_run(CTL_LF, end_of_string);
                    CH_LOW_R: base_run = hex_run(CTL_CR, end_of_string);
                    CH_LOW_T: base_run = byte_run(CH_TAB, end_of_string);
                    CH_LOW_U: base_run = base_run;
                    default:  base_run = byte_run(CH_QMARK, end_of_string);
                endcase
            end
            PH_HEX1, PH_HEX2:
            begin
                if (group_done && (phase_reg == PH_HEX2 || !is_high_surr))
                begin
                    base_run = utf8_run;
                end
            end
            PH_WANT_BS:
            begin
                if (in_byte != CH_BSLASH)
                begin
                    base_run = byte_run(CH_QMARK, end_of_string);
                end
            end
            PH_WANT_U:
            begin
                if (in_byte != CH_LOW_U)
                begin
                    base_run = byte_run(CH_QMARK, end_of_string);
                    if (in_byte != CH_BSLASH)
                    begin
                        base_run.data[1] = in_byte;
                        base_run.count   = CNT_W'(2);
                    end
                end
            end
            default:
            begin
                if (in_byte != CH_BSLASH)
                begin
                    base_run = byte_run(in_byte, end_of_string);
                end
            end
        endcase
    end

    // An escape left open at the end of the string adds one '?'; the run
    // holds at most one byte in that case.
    always_comb
    begin
        run = base_run;
        if (end_of_string && phase_raw != PH_IDLE)
        begin
            if (base_run.count == '0)
            begin
                run.data[0] = CH_QMARK;
                run.count   = CNT_W'(1);
            end
            else
            begin
                run.data[1] = CH_QMARK;
                run.count   = CNT_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seen_reg  <= 2'd0;
            acc_reg   <= 16'd0;
            hs_reg    <= 10'd0;
        end
        else if (advance)
        begin
            hs_reg <= hs_next;
            if (end_of_string && phase_raw != PH_IDLE)
            begin
                phase_reg <= PH_IDLE;
                seen_reg  <= 2'd0;
                acc_reg   <= 16'd0;
            end
            else
            begin
                phase_reg <= phase_raw;
                seen_reg  <= seen_raw;
                acc_reg   <= acc_raw;
            end
        end
    end

    assign phase = phase_reg;

endmodule

@@ src/jsu_emitter.sv @@
`timescale 1ns / 1ps
// Run buffer and output register: drains one decoded run onto the output channel
// a byte per cycle while the output is not stalled. Depends on jsu_pkg.
module jsu_emitter
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       run,
    input  logic       load,
    output logic       take,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_end
);

    logic [RUN_MAX-1:0][7:0] data_reg, data_shift;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    eos_reg;
    logic                    valid_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;
    logic                    end_reg;
    logic                    out_load;
    logic                    run_final;

    assign run_final = (cnt_reg == CNT_W'(1));
    assign out_load  = (cnt_reg != '0) && (!valid_reg || !out_stall);
    // Free for a new run when empty or when its final byte leaves this cycle
    assign take      = (cnt_reg == '0) || (out_load && run_final);

    always_comb
    begin
        for (int i = 0; i < RUN_MAX; i++)
        begin
            data_shift[i] = (i < RUN_MAX - 1) ? data_reg[(i + 1) % RUN_MAX] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cnt_reg <= run.count;
            end
            else if (out_load)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (valid_reg && !out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= run.data;
            eos_reg  <= run.eos;
        end
        else if (out_load)
        begin
            data_reg <= data_shift;
        end

        if (out_load)
        begin
            byte_reg <= data_reg[0];
            last_reg <= run_final;
            end_reg  <= run_final && eos_reg;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign string_end  = end_reg;

endmodule

@@ src/json_unescape_to_hex_utf8_top.sv @@
`timescale 1ns / 1ps
// JSON string unescaper, top level: escape parser feeding the output emitter.
// Depends on jsu_pkg, jsu_parser and jsu_emitter.
//
// Feed the body of a JSON string a byte per word, with end_of_string on the
// final byte. Plain bytes pass through; simple escapes give their character,
// \b \f \n \r and \u code points come out as UTF-8 bytes written "~HH" in
// upper-case hex. Plain text streams at a byte per cycle while the output is
// not stalled. A byte that yields N output bytes (up to 12 for a surrogate
// pair) holds in_stall until the last byte of its run moves to the output
// register: the decoded run drains through the single output register one
// byte per cycle while the output is not stalled. One run can be taken while
// the previous final byte still waits on a stalled output. An accepted byte
// passes through the run buffer and then the output register. There are no
// configuration registers.
module json_unescape_to_hex_utf8_top
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       string_end
);

    run_t   run;
    phase_t phase;
    logic   take;
    logic   accept;

    assign in_stall = !take;
    assign accept   = in_valid && take;

    jsu_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .run           (run),
        .phase         (phase)
    );

    jsu_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .run         (run),
        .load        (accept),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

`ifndef SYNTHESIS
    a_eos_idle : assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> phase == PH_IDLE)
        else $error("escape still open after end of string");

    a_eos_output : assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |-> run.count != '0)
        else $error("end of string produced no output word");

    a_run_bound : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> run.count <= CNT_W'(RUN_MAX))
        else $error("run longer than buffer");

    a_long_run_stall : assert property (@(posedge clk) disable iff (!rst_n)
        accept && run.count > CNT_W'(1) |=> in_stall)
        else $error("input taken while a multi-byte run drains");
`endif

endmodule

@@ dv/tb_json_unescape_to_hex_utf8_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for json_unescape_to_hex_utf8_top: directed and random escaped strings,
// predicted output text compared word by word under several idle and stall mixes.
// Depends on jsu_pkg and the unescaper RTL.
module tb_json_unescape_to_hex_utf8_top
    import jsu_pkg::*;
();

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int BATCH_WORDS = 64;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } in_word_t;

    // Tracks the unescaper state and holds the text it should emit.
    class unescape_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       run_last;
            logic       str_last;
        } text_word_t;

        text_word_t  pending_text[$];
        logic [7:0]  run_text[$];
        phase_t      phase;
        logic [1:0]  digits;
        logic [15:0] code_acc;
        logic [9:0]  high_bits;
        int          errors;
        int          words_checked;

        function new();
            phase = PH_IDLE;
            digits = '0;
            code_acc = '0;
            high_bits = '0;
            errors = 0;
            words_checked = 0;
        endfunction

        function void emit(logic [7:0] c);
            if (run_text.size() < RUN_MAX)
                run_text.push_back(c);
        endfunction

        function logic [7:0] nibble_char(logic [3:0] n);
            return (n < 4'd10) ? 8'("0" + n) : 8'(CH_UPPER_A + n - 10);
        endfunction

        function void emit_hex(logic [7:0] v);
            emit(CH_TILDE);
            emit(nibble_char(v[7:4]));
            emit(nibble_char(v[3:0]));
        endfunction

        function logic [3:0] digit_value(logic [7:0] c);
            logic [7:0] d;
            d = c;
            if (d >= CH_UPPER_A)
                d = (d & 8'hDF) - 8'd7;
            d = d - 8'("0");
            return d[3:0];
        endfunction

        function void emit_utf8(logic [31:0] cp);
            if (cp < 32'h80)
            begin
                emit_hex(cp[7:0]);
            end
            else if (cp < 32'h800)
            begin
                emit_hex(8'hC0 | 8'(cp >> 6));
                emit_hex(8'h80 | {2'b00, cp[5:0]});
            end
            else if (cp < 32'h10000)
            begin
                emit_hex(8'hE0 | 8'(cp >> 12));
                emit_hex(8'h80 | {2'b00, cp[11:6]});
                emit_hex(8'h80 | {2'b00, cp[5:0]});
            end
            else if (cp < 32'h200000)
            begin
                emit_hex(8'hF0 | 8'(cp >> 18));
                emit_hex(8'h80 | {2'b00, cp[17:12]});
                emit_hex(8'h80 | {2'b00, cp[11:6]});
                emit_hex(8'h80 | {2'b00, cp[5:0]});
            end
            else
            begin
                emit(CH_QMARK);
            end
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == CH_BSLASH)
                phase = PH_ESC;
            else
                emit(b);
        endfunction

        function void decode_byte(logic [7:0] b);
            case (phase)
                PH_ESC:
                begin
                    phase = PH_IDLE;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b);
                        CH_LOW_B: emit_hex(CTL_BS);
                        CH_LOW_F: emit_hex(CTL_FF);
                        CH_LOW_N: emit_hex(CTL_LF);
                        CH_LOW_R: emit_hex(CTL_CR);
                        CH_LOW_T: emit(CH_TAB);
                        CH_LOW_U:
                        begin
                            phase = PH_HEX1;
                            digits = '0;
                            code_acc = '0;
                        end
                        default: emit(CH_QMARK);
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    code_acc = {code_acc[11:0], digit_value(b)};
                    if (digits < 2'd3)
                    begin
                        digits++;
                    end
                    else
                    begin
                        digits = '0;
                        if (phase == PH_HEX2)
                        begin
                            emit_utf8(32'h10000 + {12'b0, high_bits, 10'b0}
                                      + {22'b0, code_acc[9:0]});
                            phase = PH_IDLE;
                        end
                        else if (code_acc[15:10] == SURR_HIGH_TAG)
                        begin
                            high_bits = code_acc[9:0];
                            phase = PH_WANT_BS;
                        end
                        else
                        begin
                            emit_utf8({16'b0, code_acc});
                            phase = PH_IDLE;
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    // drop the byte after a lone high surrogate unless it opens an escape
                    if (b == CH_BSLASH)
                    begin
                        phase = PH_WANT_U;
                    end
                    else
                    begin
                        emit(CH_QMARK);
                        phase = PH_IDLE;
                    end
                end
                PH_WANT_U:
                begin
                    if (b == CH_LOW_U)
                    begin
                        phase = PH_HEX2;
                        digits = '0;
                        code_acc = '0;
                    end
                    else
                    begin
                        emit(CH_QMARK);
                        phase = PH_IDLE;
                        plain_byte(b);
                    end
                end
                default:
                begin
                    phase = PH_IDLE;
                    plain_byte(b);
                end
            endcase
        endfunction

        function void note_word(logic [7:0] b, logic eos);
            text_word_t w;
            run_text.delete();
            decode_byte(b);
            if (eos && phase != PH_IDLE)
            begin
                emit(CH_QMARK);
                phase = PH_IDLE;
                digits = '0;
                code_acc = '0;
            end
            foreach (run_text[k])
            begin
                w.ch = run_text[k];
                w.run_last = (k == run_text.size() - 1);
                w.str_last = eos && (k == run_text.size() - 1);
                pending_text.push_back(w);
            end
        endfunction

        function void check_word(logic [7:0] ch, logic run_last, logic str_last);
            text_word_t w;
            words_checked++;
            if (pending_text.size() == 0)
            begin
                $error("unexpected output word: out_byte=%h", ch);
                errors++;
                return;
            end
            w = pending_text.pop_front();
            if (ch !== w.ch)
            begin
                $error("out_byte: expected %h, got %h", w.ch, ch);
                errors++;
            end
            if (run_last !== w.run_last)
            begin
                $error("last_of_run: expected %b, got %b", w.run_last, run_last);
                errors++;
            end
            if (str_last !== w.str_last)
            begin
                $error("string_end: expected %b, got %b", w.str_last, str_last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_string;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_end;

    unescape_scoreboard text_board;
    in_word_t           send_q[$];
    logic [7:0]         str_bytes[$];
    int                 idle_pct;
    int                 stall_pct;
    bit                 hold_req;
    int                 words_sent;
    int                 strings_built;

    json_unescape_to_hex_utf8_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .string_end    (string_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Close the current string; optionally cut it short so an escape stays open.
    function automatic void close_string(bit allow_cut);
        int cut;
        in_word_t w;
        if (str_bytes.size() == 0)
            return;
        if (allow_cut && $urandom_range(99) < 15)
        begin
            cut = $urandom_range(str_bytes.size(), 1);
            while (str_bytes.size() > cut)
                void'(str_bytes.pop_back());
        end
        foreach (str_bytes[i])
        begin
            w.ch = str_bytes[i];
            w.eos = (i == str_bytes.size() - 1);
            send_q.push_back(w);
        end
        str_bytes.delete();
        strings_built++;
    endfunction

    function automatic void add_hex4(logic [15:0] v);
        logic [3:0] n;
        for (int i = 3; i >= 0; i--)
        begin
            n = v[i*4 +: 4];
            case ($urandom_range(15))
                0: str_bytes.push_back(8'($urandom_range(255)));
                1, 2: str_bytes.push_back((n < 4'd10) ? 8'("0" + n) : 8'("a" + n - 10));
                default: str_bytes.push_back((n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 10));
            endcase
        end
    endfunction

    function automatic void add_unicode(logic [15:0] v);
        str_bytes.push_back(CH_BSLASH);
        str_bytes.push_back(CH_LOW_U);
        add_hex4(v);
    endfunction

    function automatic void add_segment();
        logic [7:0] simple_esc[8];
        logic [15:0] cp;
        simple_esc = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                       CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
        case ($urandom_range(9))
            0, 1, 2: str_bytes.push_back(8'($urandom_range(255)));
            3:
            begin
                str_bytes.push_back(CH_BSLASH);
                str_bytes.push_back(simple_esc[$urandom_range(7)]);
            end
            4:
            begin
                str_bytes.push_back(CH_BSLASH);
                str_bytes.push_back(8'($urandom_range(255)));
            end
            5, 6:
            begin
                case ($urandom_range(2))
                    0: cp = 16'($urandom_range(16'h7F));
                    1: cp = 16'($urandom_range(16'h7FF, 16'h80));
                    default: cp = 16'($urandom_range(16'hFFFF, 16'h800));
                endcase
                add_unicode(cp);
            end
            7:
            begin
                add_unicode(16'hD800 | 16'($urandom_range(16'h3FF)));
                if ($urandom_range(3) == 0)
                    add_unicode(16'($urandom_range(16'hFFFF)));
                else
                    add_unicode(16'hDC00 | 16'($urandom_range(16'h3FF)));
            end
            8:
            begin
                add_unicode(16'hD800 | 16'($urandom_range(16'h3FF)));
                if ($urandom_range(1) == 0)
                    str_bytes.push_back(8'($urandom_range(255)));
                else
                begin
                    str_bytes.push_back(CH_BSLASH);
                    str_bytes.push_back(8'($urandom_range(255)));
                end
            end
            default:
            begin
                case ($urandom_range(2))
                    0: str_bytes.push_back(CH_BSLASH);
                    1: str_bytes.push_back(CH_LOW_U);
                    default: str_bytes.push_back(8'("A" + $urandom_range(5)));
                endcase
            end
        endcase
    endfunction

    function automatic void build_batch(int target);
        int start;
        start = send_q.size();
        while (send_q.size() - start < target)
        begin
            repeat ($urandom_range(8, 1))
                add_segment();
            close_string(1'b1);
        end
    endfunction

    task automatic send_all();
        in_word_t w;
        while (send_q.size() > 0)
        begin
            w = send_q.pop_front();
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte <= w.ch;
            end_of_string <= w.eos;
            do
                @(posedge clk);
            while (in_stall);
            text_board.note_word(w.ch, w.eos);
            words_sent++;
        end
        // deassert valid so the next batch drives valid at a later edge
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: check accepted words, then pick the stall for the next cycle.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                text_board.check_word(out_byte, last_of_run, string_end);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        int failures;
        idle_mix = '{0, 87, 0, 34};
        stall_mix = '{0, 0, 87, 34};
        text_board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        end_of_string = 1'b0;
        out_stall = 1'b0;
        hold_req = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        words_sent = 0;
        strings_built = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme bytes, every simple escape, an unknown escape.
        str_bytes = '{8'h00, 8'hFF,
                      CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
                      CH_BSLASH, CH_LOW_B, CH_BSLASH, CH_LOW_F, CH_BSLASH, CH_LOW_N,
                      CH_BSLASH, CH_LOW_R, CH_BSLASH, CH_LOW_T, CH_BSLASH, 8'h71};
        // Lone high surrogate, then a backslash that does not open a second \u.
        add_unicode(16'hD800);
        str_bytes.push_back(CH_BSLASH);
        str_bytes.push_back(CH_LOW_N);
        close_string(1'b0);
        // String that ends on an open escape.
        str_bytes.push_back(CH_BSLASH);
        close_string(1'b0);
        send_all();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            build_batch(BATCH_WORDS);
            send_all();
        end

        // Hold the output off for a long stretch while input keeps coming.
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        build_batch(BATCH_WORDS);
        send_all();

        while (text_board.pending_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        failures = text_board.errors;
        if (text_board.pending_text.size() != 0)
        begin
            $error("%0d expected output words never arrived", text_board.pending_text.size());
            failures++;
        end
        $display("covered %0d input words in %0d strings over five idle/stall mixes,",
                 words_sent, strings_built);
        $display("including a long output hold; %0d output words checked",
                 text_board.words_checked);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/jsu_pkg.sv
src/jsu_parser.sv
src/jsu_emitter.sv
src/json_unescape_to_hex_utf8_top.sv
dv/tb_json_unescape_to_hex_utf8_top.sv
